// ===== hw/rtl/ebf_pkg.sv =====
package ebf_pkg;

   localparam int CHAN_W     = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   // request opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   // one column of the 3x3 window
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } win_col_type;

   // one line buffer entry: the two rows above the current column
   typedef struct packed {
      pix_type above;
      pix_type two_above;
   } line_entry_type;

endpackage

// ===== hw/rtl/ebf_if.sv =====
interface ebf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [ebf_pkg::CHAN_W-1:0]    in_red;
   logic [ebf_pkg::CHAN_W-1:0]    in_green;
   logic [ebf_pkg::CHAN_W-1:0]    in_blue;

   modport source (output valid, op, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface ebf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ebf_pkg::CHAN_W-1:0]    out_red;
   logic [ebf_pkg::CHAN_W-1:0]    out_green;
   logic [ebf_pkg::CHAN_W-1:0]    out_blue;
   logic                          frame_end;

   modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface ebf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ebf_pkg::CSR_IDX_W-1:0]     index;
   logic [ebf_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/emboss_3x3_filter.sv =====
// 3x3 emboss filter, RGB raster stream, one item per clock unless output stalls.
// A transfer lands in the window stage; its result (if any) goes to the output
// register when the stage advances. In pixel terms a result trails its input
// by one row plus one pixel; image_width+1 drain items flush the frame.
// Line buffer does one read and one write a cycle; only output backpressure stalls.
// Reset: sizes go to 640x480, counters and window clear, line buffer kept.
module emboss_3x3_filter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic      clock,
   input  logic      reset,
   ebf_req_if.sink   req_ch,
   ebf_rsp_if.source rsp_ch,
   ebf_csr_if.sink   csr_ch
);
   import ebf_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int TW = WW + HW;
   localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
   localparam int RST_TOTAL = RST_W * RST_H;

   function automatic logic [CHAN_W-1:0] emboss(
      input logic [CHAN_W-1:0] a0, input logic [CHAN_W-1:0] b0,
      input logic [CHAN_W-1:0] a1, input logic [CHAN_W-1:0] b1,
      input logic [CHAN_W-1:0] s1, input logic [CHAN_W-1:0] b2,
      input logic [CHAN_W-1:0] s2);
      logic signed [CHAN_W+3:0] sum;
      sum = $signed({4'b0, b1}) + $signed({4'b0, s1}) + $signed({4'b0, b2})
          + $signed({3'b0, s2, 1'b0})
          - $signed({3'b0, a0, 1'b0}) - $signed({4'b0, b0}) - $signed({4'b0, a1});
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed((CHAN_W+4)'(255))) begin
         return CHAN_W'(255);
      end else begin
         return sum[CHAN_W-1:0];
      end
   endfunction

   // frame geometry
   logic [WW-1:0] w_ff;
   logic [HW-1:0] h_ff;
   logic [TW-1:0] total_ff;
   logic [WW-1:0] new_w;
   logic [HW-1:0] new_h;

   // input-side position and output-side position
   logic [TW-1:0] k_ff, emit_cnt_ff;
   logic [AW-1:0] col_ff, ocol_ff;
   logic [HW-1:0] orow_ff;

   // window stage
   logic           a_valid_ff, a_emit_ff, a_inner_ff, a_last_ff;
   pix_type        a_pix_ff;
   logic [AW-1:0]  a_col_ff;
   line_entry_type rd_ff, wr_entry;
   win_col_type    win_a_ff, win_b_ff, cur_col;

   line_entry_type lbuf_mem [MAX_WIDTH];

   // output register
   logic    rsp_valid_ff;
   pix_type rsp_pix_ff, result;
   logic    rsp_last_ff;

   logic    req_xfer, csr_xfer, is_drain, done, take, emit, inner, last;
   logic    col_wrap, ocol_wrap, out_free, advance;
   pix_type in_pix;

   assign csr_ch.ready = 1'b1;
   assign csr_xfer     = csr_ch.valid;

   always_comb begin
      if (csr_ch.data == '0) begin
         new_w = WW'(1);
      end else if (int'(csr_ch.data) > MAX_WIDTH) begin
         new_w = WW'(MAX_WIDTH);
      end else begin
         new_w = WW'(csr_ch.data);
      end
      if (csr_ch.data == '0) begin
         new_h = HW'(1);
      end else if (int'(csr_ch.data) > MAX_HEIGHT) begin
         new_h = HW'(MAX_HEIGHT);
      end else begin
         new_h = HW'(csr_ch.data);
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = a_valid_ff && (!a_emit_ff || out_free);
   assign req_ch.ready = !a_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // per-item decisions, made at transfer
   always_comb begin
      is_drain  = (req_ch.op == OP_DRAIN);
      done      = (k_ff >= total_ff);
      take      = is_drain ? done : !done;
      emit      = take && (k_ff > TW'(w_ff)) && (emit_cnt_ff < total_ff);
      inner     = (orow_ff != '0) && ((HW+1)'(orow_ff) + 1'b1 < (HW+1)'(h_ff))
               && (ocol_ff != '0) && ((WW+1)'(ocol_ff) + 1'b1 < (WW+1)'(w_ff));
      last      = emit && (emit_cnt_ff + 1'b1 == total_ff);
      col_wrap  = ((WW+1)'(col_ff) + 1'b1 >= (WW+1)'(w_ff));
      ocol_wrap = ((WW+1)'(ocol_ff) + 1'b1 >= (WW+1)'(w_ff));
      in_pix    = is_drain ? '0 : pix_type'{red: req_ch.in_red, green: req_ch.in_green,
                                            blue: req_ch.in_blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= WW'(RST_W);
         h_ff        <= HW'(RST_H);
         total_ff    <= TW'(RST_TOTAL);
         k_ff        <= '0;
         emit_cnt_ff <= '0;
         col_ff      <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
      end else if (csr_xfer && (csr_ch.index == REG_IMAGE_WIDTH ||
                                csr_ch.index == REG_IMAGE_HEIGHT)) begin
         if (csr_ch.index == REG_IMAGE_WIDTH) begin
            w_ff     <= new_w;
            total_ff <= TW'(new_w) * TW'(h_ff);
         end else begin
            h_ff     <= new_h;
            total_ff <= TW'(w_ff) * TW'(new_h);
         end
         k_ff        <= '0;
         emit_cnt_ff <= '0;
         col_ff      <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
      end else if (req_xfer && take) begin
         if (last) begin
            k_ff        <= '0;
            emit_cnt_ff <= '0;
            col_ff      <= '0;
            ocol_ff     <= '0;
            orow_ff     <= '0;
         end else begin
            k_ff   <= k_ff + 1'b1;
            col_ff <= col_wrap ? '0 : col_ff + 1'b1;
            if (emit) begin
               emit_cnt_ff <= emit_cnt_ff + 1'b1;
               ocol_ff     <= ocol_wrap ? '0 : ocol_ff + 1'b1;
               if (ocol_wrap) begin
                  orow_ff <= orow_ff + 1'b1;
               end
            end
         end
      end
   end

   // window stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         a_valid_ff <= take;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_emit_ff  <= emit;
         a_inner_ff <= inner;
         a_last_ff  <= last;
         a_pix_ff   <= in_pix;
         a_col_ff   <= col_ff;
      end
   end

   assign cur_col  = '{top: rd_ff.two_above, mid: rd_ff.above, bot: a_pix_ff};
   assign wr_entry = '{above: a_pix_ff, two_above: rd_ff.above};

   // line buffer; the bypass covers a one-pixel-wide frame
   always_ff @(posedge clock) begin
      if (advance) begin
         lbuf_mem[a_col_ff] <= wr_entry;
      end
      if (req_xfer) begin
         if (advance && a_col_ff == col_ff) begin
            rd_ff <= wr_entry;
         end else begin
            rd_ff <= lbuf_mem[col_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_a_ff <= '0;
         win_b_ff <= '0;
      end else if (advance) begin
         win_a_ff <= win_b_ff;
         win_b_ff <= cur_col;
      end
   end

   always_comb begin
      if (a_inner_ff) begin
         result.red   = emboss(win_a_ff.top.red, win_b_ff.top.red, win_a_ff.mid.red,
                               win_b_ff.mid.red, cur_col.mid.red, win_b_ff.bot.red,
                               cur_col.bot.red);
         result.green = emboss(win_a_ff.top.green, win_b_ff.top.green, win_a_ff.mid.green,
                               win_b_ff.mid.green, cur_col.mid.green, win_b_ff.bot.green,
                               cur_col.bot.green);
         result.blue  = emboss(win_a_ff.top.blue, win_b_ff.top.blue, win_a_ff.mid.blue,
                               win_b_ff.mid.blue, cur_col.mid.blue, win_b_ff.bot.blue,
                               cur_col.bot.blue);
      end else begin
         result = win_b_ff.mid;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && a_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_emit_ff) begin
         rsp_pix_ff  <= result;
         rsp_last_ff <= a_last_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_red   = rsp_pix_ff.red;
   assign rsp_ch.out_green = rsp_pix_ff.green;
   assign rsp_ch.out_blue  = rsp_pix_ff.blue;
   assign rsp_ch.frame_end = rsp_last_ff;

endmodule

// ===== tb/tb_emboss_3x3_filter.sv =====
`timescale 1ns / 1ps

module tb_emboss_3x3_filter;
   import ebf_pkg::*;

   localparam int LINE_DEPTH  = 2048;
   localparam int FRAME_ROWS  = 2048;
   localparam int RANDOM_ITEMS = 600;
   // no register lives here; writes to it must leave the frame alone
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(15);

   typedef struct packed {
      pix_type pix;
      logic    frame_end;
   } emboss_out_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_type;

   class emboss_scoreboard;
      int unsigned frame_w, frame_h;
      pix_type     row_above[LINE_DEPTH];
      pix_type     row_two_above[LINE_DEPTH];
      pix_type     win[6];
      int unsigned col_idx, row_idx, out_idx;
      emboss_out_type expected_pixels[$];
      int unsigned failures, results_checked, interior_seen, frames_done;
      int unsigned used_items, ignored_items, reg_writes;

      function new();
         foreach (row_above[i]) begin
            row_above[i] = '0;
            row_two_above[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         frame_w = 640;
         frame_h = 480;
         restart_frame();
      endfunction

      function void restart_frame();
         col_idx = 0;
         row_idx = 0;
         out_idx = 0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("ERROR: %s", msg);
      endfunction

      function int unsigned clamp_size(logic [CSR_DATA_W-1:0] value, int unsigned maxv);
         if (value == 0) return 1;
         if (value > maxv) return maxv;
         return value;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         reg_writes++;
         if (idx == REG_IMAGE_WIDTH) begin
            frame_w = clamp_size(value, LINE_DEPTH);
            restart_frame();
         end else if (idx == REG_IMAGE_HEIGHT) begin
            frame_h = clamp_size(value, FRAME_ROWS);
            restart_frame();
         end
      endfunction

      // window taps: tl/ml = left column, tc/mc/bc = center column, mr/br = right column
      function logic [7:0] emboss_level(int tl, int tc, int ml, int mc, int mr, int bc, int br);
         int acc;
         acc = mc + mr + bc + 2 * br - 2 * tl - tc - ml;
         if (acc > 255) acc = 255;
         else if (acc < 0) acc = 0;
         return 8'(acc);
      endfunction

      function void take_pixel(logic op, pix_type px);
         int unsigned total, pos, c, orow, ocol;
         pix_type     s0, s1, s2;
         emboss_out_type r;
         bit          last;
         total = frame_w * frame_h;
         pos = row_idx * frame_w + col_idx;
         if ((op == OP_PIXEL && pos >= total) || (op == OP_DRAIN && pos < total)) begin
            ignored_items++;
            return;
         end
         used_items++;
         if (op == OP_DRAIN) px = '0;
         c = (col_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_idx;
         s0 = row_two_above[c];
         s1 = row_above[c];
         s2 = px;
         last = 1'b0;
         if (pos >= frame_w + 1 && out_idx < total) begin
            orow = out_idx / frame_w;
            ocol = out_idx % frame_w;
            if (orow >= 1 && orow + 1 < frame_h && ocol >= 1 && ocol + 1 < frame_w) begin
               r.pix.red   = emboss_level(win[0].red, win[3].red, win[1].red, win[4].red,
                                          s1.red, win[5].red, s2.red);
               r.pix.green = emboss_level(win[0].green, win[3].green, win[1].green,
                                          win[4].green, s1.green, win[5].green, s2.green);
               r.pix.blue  = emboss_level(win[0].blue, win[3].blue, win[1].blue, win[4].blue,
                                          s1.blue, win[5].blue, s2.blue);
               interior_seen++;
            end else begin
               r.pix = win[4];
            end
            out_idx++;
            last = (out_idx == total);
            r.frame_end = last;
            expected_pixels.push_back(r);
         end
         win[0] = win[3];
         win[1] = win[4];
         win[2] = win[5];
         win[3] = s0;
         win[4] = s1;
         win[5] = s2;
         row_two_above[c] = s1;
         row_above[c] = s2;
         col_idx++;
         if (col_idx >= frame_w) begin
            col_idx = 0;
            row_idx++;
         end
         if (last) begin
            frames_done++;
            restart_frame();
         end
      endfunction

      function void check_output(emboss_out_type got);
         emboss_out_type want;
         if (expected_pixels.size() == 0) begin
            flag($sformatf("unexpected output rgb=%02h,%02h,%02h end=%b",
                           got.pix.red, got.pix.green, got.pix.blue, got.frame_end));
            return;
         end
         want = expected_pixels.pop_front();
         results_checked++;
         if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
             got.pix.blue !== want.pix.blue || got.frame_end !== want.frame_end)
            flag($sformatf("output %0d: expected %02h,%02h,%02h/%b, got %02h,%02h,%02h/%b",
                           results_checked - 1, want.pix.red, want.pix.green, want.pix.blue,
                           want.frame_end, got.pix.red, got.pix.green, got.pix.blue,
                           got.frame_end));
      endfunction
   endclass

   logic clock;
   logic reset;

   ebf_req_if req_ch ();
   ebf_rsp_if rsp_ch ();
   ebf_csr_if csr_ch ();

   emboss_3x3_filter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   emboss_scoreboard sb;
   int unsigned      burst_left = 0;
   int unsigned      stall_left = 0;
   int unsigned      mode_left = 0;
   rx_mode_type      rx_mode = RX_ALWAYS;

   always #10 clock = ~clock;

   // transfers are sampled here only
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_output({rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue,
                             rsp_ch.frame_end});
         if (req_ch.valid && req_ch.ready)
            sb.take_pixel(req_ch.op, {req_ch.in_red, req_ch.in_green, req_ch.in_blue});
         if (csr_ch.valid && csr_ch.ready)
            sb.write_register(csr_ch.index, csr_ch.data);
      end
   end

   // output backpressure: switches between always ready, random ready and bursts of stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(40, 400);
      end else begin
         mode_left--;
      end
      case (rx_mode)
         RX_ALWAYS: rsp_ch.ready <= 1'b1;
         RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         default: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   function automatic logic [7:0] rand_level();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pix_type rand_pix();
      pix_type p;
      p.red = rand_level();
      p.green = rand_level();
      p.blue = rand_level();
      return p;
   endfunction

   task automatic send_item(input logic op, input pix_type px);
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.in_red <= px.red;
      req_ch.in_green <= px.green;
      req_ch.in_blue <= px.blue;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   // bursts of back-to-back transfers, then a gap with junk on the bus
   task automatic paced_send(input logic op, input pix_type px);
      send_item(op, px);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 12);
         req_ch.valid <= 1'b0;
         req_ch.op <= 1'($urandom_range(0, 1));
         req_ch.in_red <= 8'($urandom);
         req_ch.in_green <= 8'($urandom);
         req_ch.in_blue <= 8'($urandom);
         if ($urandom_range(0, 30) == 0)
            while (sb.expected_pixels.size() != 0) @(negedge clock);
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // wait for the filter to go idle before touching the registers
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // one well-formed frame with random content, sometimes cut short,
   // with occasional out-of-place items the filter should drop
   task automatic run_frame(input int unsigned w, input int unsigned h);
      int unsigned npix, cut;
      npix = w * h;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix + w) : npix + w + 1;
      for (int unsigned i = 0; i < cut; i++) begin
         if ($urandom_range(0, 19) == 0)
            paced_send((i < npix) ? OP_DRAIN : OP_PIXEL, rand_pix());
         paced_send((i < npix) ? OP_PIXEL : OP_DRAIN, rand_pix());
      end
      if ($urandom_range(0, 5) == 0) paced_send(OP_DRAIN, rand_pix());
   endtask

   initial begin
      #20_000_000;
      $display("TIMEOUT: filter stopped making progress");
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      pix_type           px;
      logic [11:0]       red_mask;
      int unsigned       w, h, start_used, wait_cycles;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_PIXEL;
      req_ch.in_red = '0;
      req_ch.in_green = '0;
      req_ch.in_blue = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // reset size 640x480: one row plus a bit, then a write to a spare index
      paced_send(OP_DRAIN, rand_pix());
      repeat (680) paced_send(OP_PIXEL, rand_pix());
      settle();
      write_csr(REG_SPARE, 12'hFFF);
      repeat (20) paced_send(OP_PIXEL, rand_pix());

      // 4x3 frame: one interior pixel saturates low, the other high
      settle();
      write_csr(REG_IMAGE_WIDTH, 12'd4);
      write_csr(REG_IMAGE_HEIGHT, 12'd3);
      red_mask = 12'b1100_1000_0011;
      paced_send(OP_DRAIN, rand_pix());
      for (int i = 0; i < 12; i++) begin
         px.red = red_mask[i] ? 8'hFF : 8'h00;
         px.green = ~px.red;
         px.blue = 8'(i * 23);
         paced_send(OP_PIXEL, px);
      end
      paced_send(OP_PIXEL, '1);
      repeat (5) paced_send(OP_DRAIN, rand_pix());
      paced_send(OP_DRAIN, '0);

      // single-row frame: first drain gives nothing
      settle();
      write_csr(REG_IMAGE_HEIGHT, 12'd1);
      write_csr(REG_IMAGE_WIDTH, 12'd3);
      repeat (3) paced_send(OP_PIXEL, rand_pix());
      repeat (4) paced_send(OP_DRAIN, rand_pix());

      h = 1;
      start_used = sb.used_items;
      while (sb.used_items - start_used < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 16);
         settle();
         write_csr(REG_IMAGE_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 12'd0 : 12'(w));
         if ($urandom_range(0, 4) != 0) begin
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            write_csr(REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? 12'd0 : 12'(h));
         end
         repeat ($urandom_range(1, 3)) run_frame(w, h);
      end

      // oversize width clamps to a full line buffer: no output within the first row
      settle();
      write_csr(REG_IMAGE_WIDTH, 12'hFFF);
      write_csr(REG_IMAGE_HEIGHT, 12'h000);
      repeat (40) paced_send(OP_PIXEL, rand_pix());
      repeat (4) paced_send(OP_DRAIN, rand_pix());

      // one pixel wide, oversize height: long frame, no early frame end
      settle();
      write_csr(REG_IMAGE_WIDTH, 12'h000);
      write_csr(REG_IMAGE_HEIGHT, 12'hFFF);
      repeat (40) paced_send(OP_PIXEL, rand_pix());
      repeat (2) paced_send(OP_DRAIN, rand_pix());

      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (sb.expected_pixels.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (sb.expected_pixels.size() != 0)
         sb.flag($sformatf("%0d expected outputs never arrived", sb.expected_pixels.size()));

      $display("Covered %0d outputs (%0d embossed interior) across %0d finished frames.",
               sb.results_checked, sb.interior_seen, sb.frames_done);
      $display("Fed %0d live items and %0d dropped ones under %0d register writes.",
               sb.used_items, sb.ignored_items, sb.reg_writes);
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== emboss_3x3_filter.f =====
hw/rtl/ebf_pkg.sv
hw/rtl/ebf_if.sv
hw/rtl/emboss_3x3_filter.sv
tb/tb_emboss_3x3_filter.sv
